### src/segment_sweep_intersection_counter_macros.svh
`ifndef SEGMENT_SWEEP_INTERSECTION_COUNTER_MACROS_SVH
`define SEGMENT_SWEEP_INTERSECTION_COUNTER_MACROS_SVH

// concurrent check on a given clock and active-low reset
`define SSIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check on the block's own clock and reset
`define SSIC_ASSERT_CLK(label, prop, msg) \
    `SSIC_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

### src/ssic_pkg.sv
package ssic_pkg;

    localparam int MAX_ACTIVE = 256;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_ACTIVE);
    localparam int SEG_W      = 4 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ORI_W      = PROD_W + 1;
    localparam int ADDED_W    = 9;
    localparam int TOTAL_W    = 32;
    localparam int STATUS_W   = 2;

    localparam logic [ADDED_W-1:0]  ADDED_MAX = '1;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX = '1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } t_seg;

endpackage

### src/ssic_ram.sv
module ssic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/segment_sweep_intersection_counter.sv
// Sweep-line intersection counter. Raise start while busy is low to hand in one
// sweep event; it is taken at that rising edge and busy then stays high while
// the event runs. The result word appears on the o_ ports for exactly one cycle
// with o_strobe high, so the receiver must take it then. An event walks the
// slots of the active store one at a time; an end event stops at its match.
// An empty slot takes a scan step only. An occupied slot takes a store read
// and compare on an end event; on a start event the store read is followed by
// the single shared orientation unit (two 17x17 multipliers, then subtract and
// sign) issued four times in a row, and then an evaluate step. The result word
// appears in the cycle after the finish state, in which busy is already low,
// so the next event can be taken at the end of it. The store needs no clearing
// pass after reset; a final event clears it at once.
`include "segment_sweep_intersection_counter_macros.svh"

module segment_sweep_intersection_counter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_kind,
    input  logic signed [ssic_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [ssic_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [ssic_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [ssic_pkg::COORD_BITS-1:0] i_by,
    input  logic                                   i_final_event,
    output logic                                   o_strobe,
    output logic [ssic_pkg::ADDED_W-1:0]           o_added,
    output logic [ssic_pkg::TOTAL_W-1:0]           o_total,
    output logic [ssic_pkg::STATUS_W-1:0]          o_status,
    output logic                                   o_set_done
);

    import ssic_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_ORIENT,
        S_EVAL,
        S_FINISH
    } t_state;

    t_state                r_state;
    t_seg                  r_seg;
    t_seg                  r_ent;
    logic                  r_kind;
    logic                  r_fin;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_free_ok;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_found;
    logic [ADDED_W-1:0]    r_added;
    logic [TOTAL_W-1:0]    r_total;
    logic [MAX_ACTIVE-1:0] r_valid;
    logic [2:0]            r_op;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic [3:0]            r_nz;
    logic [3:0]            r_neg;
    logic                  r_strobe;
    logic [ADDED_W-1:0]    r_o_added;
    logic [TOTAL_W-1:0]    r_o_total;
    logic [STATUS_W-1:0]   r_o_status;
    logic                  r_o_set_done;

    t_seg                  ram_rdata;
    logic [SEG_W-1:0]      ram_rword;
    logic                  ram_we;
    logic                  last_slot;

    t_seg                     line_s;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic signed [DIFF_W-1:0] d_qx, d_qy, d_rx, d_ry;
    logic signed [PROD_W-1:0] m1, m2;
    logic signed [ORI_W-1:0]  ori;
    logic [1:0]               sgn_idx;
    logic                     same_a, same_b, pair_counts;

    assign ram_we = (r_state == S_FINISH) && (r_kind == KIND_START) && r_free_ok;

    ssic_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_ACTIVE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_seg),
        .i_raddr (r_idx),
        .o_rdata (ram_rword)
    );

    assign ram_rdata = t_seg'(ram_rword);
    assign last_slot = (r_idx == IDX_W'(MAX_ACTIVE - 1));

    // operand select for the shared orientation unit
    always_comb begin
        case (r_op)
            3'd1: begin
                line_s = r_ent;
                pt_x   = r_seg.bx;
                pt_y   = r_seg.by;
            end
            3'd2: begin
                line_s = r_seg;
                pt_x   = r_ent.ax;
                pt_y   = r_ent.ay;
            end
            3'd3: begin
                line_s = r_seg;
                pt_x   = r_ent.bx;
                pt_y   = r_ent.by;
            end
            default: begin
                line_s = r_ent;
                pt_x   = r_seg.ax;
                pt_y   = r_seg.ay;
            end
        endcase
    end

    assign d_qx = DIFF_W'(line_s.bx) - DIFF_W'(line_s.ax);
    assign d_qy = DIFF_W'(line_s.by) - DIFF_W'(line_s.ay);
    assign d_rx = DIFF_W'(pt_x) - DIFF_W'(line_s.ax);
    assign d_ry = DIFF_W'(pt_y) - DIFF_W'(line_s.ay);
    assign m1   = PROD_W'(d_qx) * PROD_W'(d_ry);
    assign m2   = PROD_W'(d_rx) * PROD_W'(d_qy);

    // sign of the orientation from the registered products
    assign ori     = ORI_W'(r_p1) - ORI_W'(r_p2);
    assign sgn_idx = 2'(r_op - 3'd1);

    assign same_a      = r_nz[0] && r_nz[1] && (r_neg[0] == r_neg[1]);
    assign same_b      = r_nz[2] && r_nz[3] && (r_neg[2] == r_neg[3]);
    assign pair_counts = !(same_a || same_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_total  <= '0;
            r_added  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_FINISH);
            r_p1     <= m1;
            r_p2     <= m2;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_seg     <= '{ax: i_ax, ay: i_ay, bx: i_bx, by: i_by};
                        r_kind    <= i_kind;
                        r_fin     <= i_final_event;
                        r_idx     <= '0;
                        r_free_ok <= 1'b0;
                        r_found   <= 1'b0;
                        r_added   <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_valid[r_idx]) begin
                        r_state <= S_LOAD;
                    end else begin
                        if (r_kind == KIND_START && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_idx;
                        end
                        if (last_slot) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_LOAD: begin
                    r_ent <= ram_rdata;
                    if (r_kind == KIND_END) begin
                        if (ram_rdata == r_seg) begin
                            r_valid[r_idx] <= 1'b0;
                            r_found        <= 1'b1;
                            r_state        <= S_FINISH;
                        end else if (last_slot) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_op    <= '0;
                        r_state <= S_ORIENT;
                    end
                end
                S_ORIENT: begin
                    if (r_op != 3'd0) begin
                        r_nz[sgn_idx]  <= (ori != '0);
                        r_neg[sgn_idx] <= ori[ORI_W-1];
                    end
                    r_op <= r_op + 3'd1;
                    if (r_op == 3'd4) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (pair_counts) begin
                        if (r_added != ADDED_MAX) begin
                            r_added <= r_added + ADDED_W'(1);
                        end
                        if (r_total != TOTAL_MAX) begin
                            r_total <= r_total + TOTAL_W'(1);
                        end
                    end
                    if (last_slot) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_FINISH: begin
                    r_o_added    <= r_added;
                    r_o_total    <= r_total;
                    r_o_set_done <= r_fin;
                    if (r_kind == KIND_START) begin
                        r_o_status <= r_free_ok ? ST_OK : ST_FULL;
                    end else begin
                        r_o_status <= r_found ? ST_OK : ST_NOT_FOUND;
                    end
                    if (r_fin) begin
                        r_valid <= '0;
                        r_total <= '0;
                    end else if (r_kind == KIND_START && r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_added    = r_o_added;
    assign o_total    = r_o_total;
    assign o_status   = r_o_status;
    assign o_set_done = r_o_set_done;

    `SSIC_ASSERT_CLK(a_finish_strobes, (r_state == S_FINISH) |=> r_strobe,
        "finish did not produce a result word")
    `SSIC_ASSERT_CLK(a_strobe_idle, r_strobe |-> (r_state == S_IDLE),
        "result word while an event is still in progress")
    `SSIC_ASSERT_CLK(a_final_clears,
        (r_strobe && r_o_set_done) |-> (r_total == '0 && r_valid == '0),
        "store or count not cleared after final event")
    `SSIC_ASSERT(a_added_bound, i_clk, i_rst_n, r_added <= ADDED_W'(MAX_ACTIVE),
        "added count beyond store depth")

endmodule

### tb/tb_segment_sweep_intersection_counter.sv
module tb_segment_sweep_intersection_counter;
    import ssic_pkg::*;

    typedef struct packed {
        logic [ADDED_W-1:0]  added;
        logic [TOTAL_W-1:0]  total;
        logic [STATUS_W-1:0] status;
        logic                set_done;
    } t_sweep_word;

    typedef struct packed {
        logic                  kind;
        logic [SEG_W-1:0]      seg;
        logic                  fin;
        logic                  typed;
        logic [ADDED_W-1:0]    added;
        logic [TOTAL_W-1:0]    total;
        logic [STATUS_W-1:0]   status;
        logic                  set_done;
    } t_dir_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_kind = KIND_START;
    logic signed [COORD_BITS-1:0] i_ax = '0;
    logic signed [COORD_BITS-1:0] i_ay = '0;
    logic signed [COORD_BITS-1:0] i_bx = '0;
    logic signed [COORD_BITS-1:0] i_by = '0;
    logic                         i_final_event = 1'b0;
    logic                         o_strobe;
    logic [ADDED_W-1:0]           o_added;
    logic [TOTAL_W-1:0]           o_total;
    logic [STATUS_W-1:0]          o_status;
    logic                         o_set_done;

    segment_sweep_intersection_counter uut (.*);

    always #5 i_clk = ~i_clk;

    // own copy of the active store
    t_seg              model_seg [MAX_ACTIVE];
    logic              model_valid [MAX_ACTIVE];
    logic [TOTAL_W-1:0] model_total;

    t_sweep_word pending_results [$];
    int          error_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          full_seen = 0;
    int          not_found_seen = 0;
    int          sets_closed = 0;
    int          sender_idle_pct = 25;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int orient_sign(t_seg l, longint rx, longint ry);
        longint v;
        v = (longint'(l.bx) - longint'(l.ax)) * (ry - longint'(l.ay))
          - (rx - longint'(l.ax)) * (longint'(l.by) - longint'(l.ay));
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit strictly_one_side(t_seg l, t_seg o);
        int s1;
        int s2;
        s1 = orient_sign(l, longint'(o.ax), longint'(o.ay));
        s2 = orient_sign(l, longint'(o.bx), longint'(o.by));
        return s1 != 0 && s1 == s2;
    endfunction

    function automatic t_sweep_word predict_sweep_event(logic kind, t_seg s, logic fin);
        t_sweep_word w;
        int          free_slot;
        bit          found;
        w = '0;
        free_slot = -1;
        found = 0;
        if (kind == KIND_START) begin
            for (int i = 0; i < MAX_ACTIVE; i++) begin
                if (model_valid[i]) begin
                    if (!strictly_one_side(model_seg[i], s) &&
                        !strictly_one_side(s, model_seg[i])) begin
                        if (w.added != ADDED_MAX) w.added++;
                        if (model_total != TOTAL_MAX) model_total++;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                model_seg[free_slot] = s;
                model_valid[free_slot] = 1'b1;
            end else begin
                w.status = ST_FULL;
            end
        end else begin
            for (int i = 0; i < MAX_ACTIVE && !found; i++) begin
                if (model_valid[i] && model_seg[i] == s) begin
                    model_valid[i] = 1'b0;
                    found = 1;
                end
            end
            if (!found) w.status = ST_NOT_FOUND;
        end
        w.total = model_total;
        w.set_done = fin;
        if (fin) begin
            foreach (model_valid[i]) model_valid[i] = 1'b0;
            model_total = '0;
        end
        return w;
    endfunction

    // hand one event word to the block; caller is at a rising edge
    task automatic send_word(logic kind, t_seg s, logic fin,
                             bit typed = 0, t_sweep_word typed_word = '0);
        t_sweep_word w;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(400, 1)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= kind;
        i_ax          <= s.ax;
        i_ay          <= s.ay;
        i_bx          <= s.bx;
        i_by          <= s.by;
        i_final_event <= fin;
        do @(posedge i_clk); while (busy);
        w = predict_sweep_event(kind, s, fin);
        if (typed) w = typed_word;
        pending_results = {pending_results, w};
        words_sent++;
        if (w.status == ST_FULL) full_seen++;
        if (w.status == ST_NOT_FOUND) not_found_seen++;
        if (fin) sets_closed++;
    endtask

    always @(posedge i_clk) begin
        t_sweep_word w;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_total, 0);
            end else begin
                w = pending_results.pop_front();
                words_checked++;
                if (o_added !== w.added)       report_mismatch("added", o_added, w.added);
                if (o_total !== w.total)       report_mismatch("total", o_total, w.total);
                if (o_status !== w.status)     report_mismatch("status", o_status, w.status);
                if (o_set_done !== w.set_done) report_mismatch("set_done", o_set_done, w.set_done);
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
        case (mode)
            0:       return COORD_BITS'($signed($urandom_range(16)) - 8);
            1:       return COORD_BITS'($urandom);
            default: return ($urandom_range(1)) ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                                : {1'b0, {(COORD_BITS-1){1'b1}}};
        endcase
    endfunction

    function automatic t_seg rand_segment();
        t_seg s;
        int   mode;
        int   pick;
        logic signed [COORD_BITS-1:0] t;
        pick = $urandom_range(99);
        mode = (pick < 55) ? 0 : ((pick < 85) ? 1 : 2);
        s.ax = rand_coord(mode);
        s.ay = rand_coord(mode);
        s.bx = rand_coord(mode);
        s.by = rand_coord(mode);
        // half axis-aligned, with the smaller endpoint coordinate first
        case ($urandom_range(3))
            0: begin
                s.by = s.ay;
                if (s.bx < s.ax) begin t = s.ax; s.ax = s.bx; s.bx = t; end
            end
            1: begin
                s.bx = s.ax;
                if (s.by < s.ay) begin t = s.ay; s.ay = s.by; s.by = t; end
            end
            default: ;
        endcase
        return s;
    endfunction

    t_dir_row dir_rows [15] = '{
        '{KIND_START, {16'h8000, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0,
          1'b1, 9'd0, 32'd0, ST_OK, 1'b0},
        '{KIND_END,   {16'd1, 16'd1, 16'd2, 16'd2}, 1'b0,
          1'b1, 9'd0, 32'd0, ST_NOT_FOUND, 1'b0},
        '{KIND_START, {16'h8000, 16'h7fff, 16'h7fff, 16'h8000}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'd0, 16'd0, 16'd10, 16'd0}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'd5, 16'hfffb, 16'd5, 16'd5}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'd10, 16'd0, 16'd20, 16'd0}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'd3, 16'd0, 16'd3, 16'd0}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_END,   {16'd0, 16'd0, 16'd10, 16'd0}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_END,   {16'd0, 16'd0, 16'd10, 16'd0}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'h8000, 16'h8000, 16'h8000, 16'h7fff}, 1'b0, 1'b0, '0, '0, '0, '0},
        '{KIND_END,   {16'd5, 16'hfffb, 16'd5, 16'd5}, 1'b1, 1'b0, '0, '0, '0, '0},
        '{KIND_START, {16'd0, 16'd0, 16'd0, 16'd0}, 1'b0,
          1'b1, 9'd0, 32'd0, ST_OK, 1'b0},
        '{KIND_END,   {16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
          1'b1, 9'd0, 32'd0, ST_OK, 1'b1},
        '{KIND_END,   {16'd7, 16'd7, 16'd7, 16'd7}, 1'b1,
          1'b1, 9'd0, 32'd0, ST_NOT_FOUND, 1'b1}
    };

    initial begin
        t_seg        s;
        t_seg        live [$];
        t_sweep_word tw;
        int          n_set;
        int          idx;
        foreach (model_valid[i]) model_valid[i] = 1'b0;
        model_total = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            tw = '{dir_rows[r].added, dir_rows[r].total, dir_rows[r].status,
                   dir_rows[r].set_done};
            send_word(dir_rows[r].kind, t_seg'(dir_rows[r].seg), dir_rows[r].fin,
                      dir_rows[r].typed, tw);
        end

        // fill the store, then one start too many, then close the set
        for (int i = 0; i <= MAX_ACTIVE; i++) send_word(KIND_START, rand_segment(), 1'b0);
        send_word(KIND_END, rand_segment(), 1'b1);

        while (words_sent < 1200) begin
            if (words_sent >= 800) sender_idle_pct = 0;
            else if (words_sent >= 550) sender_idle_pct = 45;
            live.delete();
            n_set = $urandom_range(24, 1);
            for (int k = 0; k < n_set; k++) begin
                if (live.size() > 0 && $urandom_range(99) < 35) begin
                    idx = $urandom_range(live.size() - 1);
                    s = live[idx];
                    live.delete(idx);
                    send_word(KIND_END, s, k == n_set - 1);
                end else if ($urandom_range(99) < 8) begin
                    send_word(KIND_END, rand_segment(), k == n_set - 1);
                end else begin
                    s = rand_segment();
                    live = {live, s};
                    send_word(KIND_START, s, k == n_set - 1);
                end
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d event words sent, %0d results checked, %0d sets closed",
                 words_sent, words_checked, sets_closed);
        $display("store-full drops %0d, unmatched ends %0d", full_seen, not_found_seen);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #200000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
